// File: rtl/ctlf_pkg.sv
// shared types and constants for the cache tag lookup block
`default_nettype none

package ctlf_pkg;

    localparam int ADDR_W   = 32;
    localparam int LIDX_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BITS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_LIMIT = 2'd3;

    // map modes
    localparam logic MODE_DIRECT = 1'b0;
    localparam logic MODE_ASSOC  = 1'b1;

    // priority chain passed from cell to cell
    typedef struct packed {
        logic hit;
        logic empty;
    } t_chain;

    // per cell selection result
    typedef struct packed {
        logic sel_hit;
        logic sel_empty;
    } t_cell_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_LOOK
    } t_state;

endpackage

`default_nettype wire

// File: rtl/ctlf_cell.sv
// one cache line: tag, valid bit and its link in the priority chain
`default_nettype none

module ctlf_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_look,
    input  wire logic [ctlf_pkg::ADDR_W-1:0]  i_block,
    input  wire logic                         i_wr,
    input  wire ctlf_pkg::t_chain             i_chain,
    output ctlf_pkg::t_chain                  o_chain,
    output ctlf_pkg::t_cell_stat              o_stat
);

    logic [ctlf_pkg::ADDR_W-1:0] r_tag;
    logic                        r_valid;
    logic                        w_match;
    logic                        w_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_tag <= i_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
        end
    end

    assign w_match = i_look && r_valid && (r_tag == i_block);
    assign w_empty = i_look && !r_valid;

    // first match and first empty line win
    assign o_stat.sel_hit   = w_match && !i_chain.hit;
    assign o_stat.sel_empty = w_empty && !i_chain.empty;
    assign o_chain.hit      = i_chain.hit || w_match;
    assign o_chain.empty    = i_chain.empty || w_empty;

endmodule

`default_nettype wire

// File: rtl/ctlf_mod.sv
// remainder of a block number by the line count, reciprocal multiply: lo, hi, rem steps
`default_nettype none

module ctlf_mod #(
    parameter int LINES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ctlf_pkg::ADDR_W-1:0]  i_value,
    output logic                              o_done,
    output logic [$clog2(LINES)-1:0]          o_rem
);

    localparam int LW    = $clog2(LINES);
    localparam int HALF  = ctlf_pkg::ADDR_W / 2;
    localparam int SHIFT = ctlf_pkg::ADDR_W + LW;
    localparam int RW    = ctlf_pkg::ADDR_W + 1;
    localparam int PW    = HALF + RW;
    localparam int AW    = ctlf_pkg::ADDR_W + RW;
    // ceil(2^SHIFT / LINES) gives the exact quotient for every 32 bit value
    localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) + 64'(LINES) - 64'd1) / 64'(LINES);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_W);
    localparam logic [ctlf_pkg::ADDR_W-1:0] DIVISOR = ctlf_pkg::ADDR_W'(LINES);

    // steps of one remainder
    localparam logic [1:0] STEP_LO  = 2'd0;
    localparam logic [1:0] STEP_HI  = 2'd1;
    localparam logic [1:0] STEP_REM = 2'd2;

    logic                        r_busy;
    logic [1:0]                  r_step;
    logic [ctlf_pkg::ADDR_W-1:0] r_val;
    logic [AW-1:0]               r_acc;
    logic [LW-1:0]               r_rem;
    logic [HALF-1:0]             w_half;
    logic [PW-1:0]               w_prod;
    logic [ctlf_pkg::ADDR_W-1:0] w_quot;
    logic [ctlf_pkg::ADDR_W-1:0] w_back;

    // one half of the value times the reciprocal per cycle
    assign w_half = (r_step == STEP_LO) ? r_val[HALF-1:0] : r_val[ctlf_pkg::ADDR_W-1:HALF];
    assign w_prod = PW'(w_half) * PW'(RECIP);
    assign w_quot = ctlf_pkg::ADDR_W'(r_acc >> SHIFT);
    assign w_back = w_quot * DIVISOR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_LO;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_LO;
        end else if (r_busy) begin
            if (r_step == STEP_REM) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end else if (r_busy) begin
            case (r_step)
                STEP_LO: r_acc <= AW'(w_prod);
                STEP_HI: r_acc <= r_acc + {w_prod, {HALF{1'b0}}};
                default: r_rem <= LW'(r_val - w_back);
            endcase
        end
    end

    assign o_done = r_busy && (r_step == STEP_REM);
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/cache_tag_lookup_fifo_top.sv
// top level of the cache tag lookup: control, config registers and the row of line cells
// a result is registered when its lookup step finishes, once the output register is free;
//   in direct mode, non power of two count, all lines in use: the remainder unit runs first
// one request at a time (accept, then lookup); ready again once the lookup finishes
// reset: synchronous active low; clears valid bits, fifo pointer, control and config
//   registers to their defaults; tags are not cleared and no sweep is needed
`default_nettype none

module cache_tag_lookup_fifo_top #(
    parameter int LINES = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config write port
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [ctlf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ctlf_pkg::CFG_W-1:0]       i_cfg_data,
    // request stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [31:0]                      i_s_tdata,  // [31:0] address
    // result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [7:0]                            o_m_tdata,  // [0] hit, [4:1] line_index
    output logic [0:0]                            o_m_tuser   // [0] out_of_range
);

    localparam int LW   = $clog2(LINES);
    localparam bit POW2 = ((1 << LW) == LINES);

    // config registers
    logic                          r_map_mode;
    logic [4:0]                    r_offset_bits;
    logic [2:0]                    r_line_bits;
    logic [ctlf_pkg::ADDR_W-1:0]   r_address_limit;

    // control
    ctlf_pkg::t_state              r_state;
    ctlf_pkg::t_state              n_state;
    logic [ctlf_pkg::ADDR_W-1:0]   r_block;
    logic                          r_oor;
    logic [LW-1:0]                 r_fifo_ptr;

    // output register
    logic                          r_out_valid;
    logic                          r_out_hit;
    logic                          r_out_oor;
    logic [ctlf_pkg::LIDX_W-1:0]   r_out_idx;

    logic                          w_accept;
    logic                          w_finish;
    logic                          w_full_lines;
    logic                          w_mod_start;
    logic                          w_mod_done;
    logic [LW-1:0]                 w_mod_rem;
    logic [ctlf_pkg::ADDR_W-1:0]   w_in_block;
    logic                          w_in_oor;
    logic [LW:0]                   w_n_use;
    logic [LW-1:0]                 w_mask;
    logic [LW-1:0]                 w_idx_d;
    logic [LW-1:0]                 w_enc_hit;
    logic [LW-1:0]                 w_enc_empty;
    logic [LW-1:0]                 w_fifo_idx;
    logic [LW:0]                   w_fifo_inc;
    logic [LW-1:0]                 w_idx;
    logic                          w_hit;
    logic                          w_fifo_step;
    logic [LW+3:0]                 w_idx_ext;
    logic [LINES-1:0]              w_look;
    logic [LINES-1:0]              w_wr;

    ctlf_pkg::t_chain              w_chain [LINES+1];
    ctlf_pkg::t_cell_stat          w_stat  [LINES];

    // config writes, only while idle: binds the user, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode      <= ctlf_pkg::MODE_DIRECT;
            r_offset_bits   <= 5'd4;
            r_line_bits     <= 3'd4;
            r_address_limit <= '1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ctlf_pkg::REG_MAP_MODE:      r_map_mode      <= i_cfg_data[0];
                ctlf_pkg::REG_OFFSET_BITS:   r_offset_bits   <= i_cfg_data[4:0];
                ctlf_pkg::REG_LINE_BITS:     r_line_bits     <= i_cfg_data[2:0];
                ctlf_pkg::REG_ADDRESS_LIMIT: r_address_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lines in use, capped at LINES
    assign w_full_lines = (32'(r_line_bits) >= LW);
    assign w_n_use      = w_full_lines ? (LW+1)'(LINES) : ((LW+1)'(1) << r_line_bits);
    assign w_mask       = LW'(w_n_use - (LW+1)'(1));

    // block number and range check on the incoming request
    assign w_in_block = i_s_tdata >> r_offset_bits;
    assign w_in_oor   = i_s_tdata > r_address_limit;

    assign o_s_tready = (r_state == ctlf_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    // lookup step completes once the output register is free
    assign w_finish   = (r_state == ctlf_pkg::S_LOOK) && (!r_out_valid || i_m_tready);

    // remainder unit only needed when a non power of two line count is fully used
    assign w_mod_start = w_accept && !w_in_oor && !POW2 && w_full_lines
                         && (r_map_mode == ctlf_pkg::MODE_DIRECT);

    ctlf_mod #(
        .LINES (LINES)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (w_in_block),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctlf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctlf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_mod_start ? ctlf_pkg::S_MOD : ctlf_pkg::S_LOOK;
                end
            end
            ctlf_pkg::S_MOD: begin
                if (w_mod_done) begin
                    n_state = ctlf_pkg::S_LOOK;
                end
            end
            ctlf_pkg::S_LOOK: begin
                if (w_finish) begin
                    n_state = ctlf_pkg::S_IDLE;
                end
            end
            default: n_state = ctlf_pkg::S_IDLE;
        endcase
    end

    // latch the block number of the accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_block <= w_in_block;
            r_oor   <= w_in_oor;
        end
    end

    // direct index: low block bits, or the remainder when the count is not a power of two
    assign w_idx_d = (!POW2 && w_full_lines) ? w_mod_rem : (r_block[LW-1:0] & w_mask);

    // which cells take part in the compare
    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            if (r_map_mode == ctlf_pkg::MODE_DIRECT) begin
                w_look[i] = (w_idx_d == LW'(i));
            end else begin
                w_look[i] = ((LW+1)'(i) < w_n_use);
            end
        end
    end

    assign w_chain[0] = '0;

    for (genvar g = 0; g < LINES; g++) begin : g_cell
        ctlf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_look  (w_look[g]),
            .i_block (r_block),
            .i_wr    (w_wr[g]),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_stat  (w_stat[g])
        );
    end

    // one-hot selections back to line numbers
    always_comb begin
        w_enc_hit   = '0;
        w_enc_empty = '0;
        for (int i = 0; i < LINES; i++) begin
            if (w_stat[i].sel_hit) begin
                w_enc_hit = w_enc_hit | LW'(i);
            end
            if (w_stat[i].sel_empty) begin
                w_enc_empty = w_enc_empty | LW'(i);
            end
        end
    end

    // fifo victim; a stale pointer past the lines in use falls back to line zero
    assign w_fifo_idx = ({1'b0, r_fifo_ptr} < w_n_use) ? r_fifo_ptr : '0;
    assign w_fifo_inc = {1'b0, w_fifo_idx} + (LW+1)'(1);

    assign w_hit = w_chain[LINES].hit;

    always_comb begin
        w_fifo_step = 1'b0;
        if (r_map_mode == ctlf_pkg::MODE_DIRECT) begin
            w_idx = w_idx_d;
        end else if (w_hit) begin
            w_idx = w_enc_hit;
        end else if (w_chain[LINES].empty) begin
            w_idx = w_enc_empty;
        end else begin
            w_idx       = w_fifo_idx;
            w_fifo_step = 1'b1;
        end
    end

    // fill the chosen line on a miss
    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            w_wr[i] = w_finish && !r_oor && !w_hit && (w_idx == LW'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_ptr <= '0;
        end else if (w_finish && !r_oor && w_fifo_step) begin
            r_fifo_ptr <= (w_fifo_inc < w_n_use) ? w_fifo_inc[LW-1:0] : '0;
        end
    end

    // result register
    assign w_idx_ext = {4'b0000, w_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_oor <= r_oor;
            r_out_hit <= !r_oor && w_hit;
            r_out_idx <= r_oor ? '0 : w_idx_ext[3:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_idx, r_out_hit};
    assign o_m_tuser  = r_out_oor;

endmodule

`default_nettype wire

// File: rtl/ctlf_checker.sv
// port level checks for the cache tag lookup top, bound to it
`default_nettype none

module ctlf_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             o_s_tready,
    input  wire logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [7:0]                       o_m_tdata,
    input  wire logic [0:0]                       o_m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // an out of range request reports no hit and line zero
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[4:0] == 5'd0)
        else $error("out of range result carries hit or line");

    // one request at a time: not ready right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after accept");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind cache_tag_lookup_fifo_top ctlf_checker u_ctlf_checker (.*);

`default_nettype wire

// File: sim/cache_tag_lookup_fifo_top_tb.sv
// testbench for the cache tag lookup block: directed and random requests, scoreboard checked
module cache_tag_lookup_fifo_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LINES      = 16;
    // margin kept after the last answer before config writes
    localparam int SETTLE_CYCLES  = 12;
    // long receiver hold-off, long enough for the block to back up into its input
    localparam int HOLD_CYCLES    = 300;
    // cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_REQUESTS = 100;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_MAX       = 24;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // one lookup answer as the block reports it
    typedef struct packed {
        logic                        hit;
        logic                        out_of_range;
        logic [ctlf_pkg::LIDX_W-1:0] line_index;
    } t_lookup_result;

    // tag store predictor plus the queue of answers still owed by the block
    class t_tag_store_scoreboard;
        logic                        map_mode;
        logic [4:0]                  offset_bits;
        logic [2:0]                  line_bits;
        logic [ctlf_pkg::ADDR_W-1:0] address_limit;
        logic [ctlf_pkg::ADDR_W-1:0] tags [NUM_LINES];
        bit                          line_valid [NUM_LINES];
        int unsigned                 victim_ptr;
        t_lookup_result              answers_q [$];
        int                          mismatches;

        function new();
            map_mode      = ctlf_pkg::MODE_DIRECT;
            offset_bits   = 5'd4;
            line_bits     = 3'd4;
            address_limit = '1;
            foreach (line_valid[i]) begin
                line_valid[i] = 1'b0;
                tags[i]       = '0;
            end
            victim_ptr = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [ctlf_pkg::CFG_IDX_W-1:0] idx,
                              logic [ctlf_pkg::CFG_W-1:0] val);
            case (idx)
                ctlf_pkg::REG_MAP_MODE:      map_mode      = val[0];
                ctlf_pkg::REG_OFFSET_BITS:   offset_bits   = val[4:0];
                ctlf_pkg::REG_LINE_BITS:     line_bits     = val[2:0];
                ctlf_pkg::REG_ADDRESS_LIMIT: address_limit = val;
                default: ;
            endcase
        endfunction

        // run one accepted address through the tag store and queue the answer
        function void note_request(logic [ctlf_pkg::ADDR_W-1:0] addr);
            t_lookup_result              res;
            logic [ctlf_pkg::ADDR_W-1:0] blk;
            int unsigned                 n;
            int unsigned                 idx;
            int                          found;
            res = '0;
            idx = 0;
            // lines in use saturate at the store size
            n = (line_bits >= 3'd4) ? NUM_LINES : (1 << line_bits);
            if (addr > address_limit) begin
                res.out_of_range = 1'b1;
                answers_q.push_back(res);
                return;
            end
            blk = addr >> offset_bits;
            if (map_mode == ctlf_pkg::MODE_DIRECT) begin
                idx = blk % n;
                if (line_valid[idx] && tags[idx] == blk) begin
                    res.hit = 1'b1;
                end else begin
                    tags[idx]       = blk;
                    line_valid[idx] = 1'b1;
                end
            end else begin
                found = -1;
                for (int i = 0; i < n; i++) begin
                    if (found < 0 && line_valid[i] && tags[i] == blk) found = i;
                end
                if (found >= 0) begin
                    res.hit = 1'b1;
                    idx     = found;
                end else begin
                    // lowest empty line first, then first in first out
                    for (int i = 0; i < n; i++) begin
                        if (found < 0 && !line_valid[i]) found = i;
                    end
                    if (found >= 0) begin
                        idx = found;
                    end else begin
                        // a pointer left beyond the lines in use restarts at zero
                        idx        = (victim_ptr < n) ? victim_ptr : 0;
                        victim_ptr = (idx + 1 < n) ? idx + 1 : 0;
                    end
                    tags[idx]       = blk;
                    line_valid[idx] = 1'b1;
                end
            end
            res.line_index = idx[ctlf_pkg::LIDX_W-1:0];
            answers_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s wrong, expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [7:0] tdata, logic [0:0] tuser);
            t_lookup_result want;
            if (answers_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, tdata %h tuser %b",
                             $time, tdata, tuser);
                return;
            end
            want = answers_q.pop_front();
            compare_field("hit", 4'(want.hit), 4'(tdata[0]));
            compare_field("line_index", want.line_index, tdata[4:1]);
            compare_field("out_of_range", 4'(want.out_of_range), 4'(tuser[0]));
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [ctlf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ctlf_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic [31:0]                    i_s_tdata   = '0;
    logic                           i_m_tready  = 1'b0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [7:0]                     o_m_tdata;
    logic [0:0]                     o_m_tuser;

    t_tag_store_scoreboard sb = new();

    // idling percentages for the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // hold-off requests from the stimulus, served by the receiver process
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    always #1 i_clk = ~i_clk;

    cache_tag_lookup_fifo_top #(
        .LINES (NUM_LINES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // offer one request and hold it until the block takes it, then idle at random
    task automatic send_request(input logic [31:0] addr);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_request(addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every answer is back and the block has gone quiet
    task automatic drain_requests();
        i_s_tvalid <= 1'b0;
        while (sb.answers_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ctlf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ctlf_pkg::CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // rewrite all four registers while the block is idle
    task automatic configure(input logic mode, input logic [4:0] offs,
                             input logic [2:0] lbits, input logic [31:0] limit);
        drain_requests();
        write_reg(ctlf_pkg::REG_MAP_MODE, 32'(mode));
        write_reg(ctlf_pkg::REG_OFFSET_BITS, 32'(offs));
        write_reg(ctlf_pkg::REG_LINE_BITS, 32'(lbits));
        write_reg(ctlf_pkg::REG_ADDRESS_LIMIT, limit);
        i_cfg_wr_en <= 1'b0;
    endtask

    // result side: check accepted answers, then pick tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on handshake activity of either stream
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] pool [POOL_MAX];
        int          pool_size;
        int          sel;
        t_idle_mode  cur_mode;
        logic        mode_v;
        logic [4:0]  offs_v;
        logic [2:0]  lb_v;
        logic [31:0] limit_v;
        logic [31:0] low_mask;
        logic [31:0] addr;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: direct, 16 byte blocks, 16 lines, full address range
        send_request(32'h0000_0000);   // cold miss on line 0
        send_request(32'h0000_000F);   // same block, hit
        send_request(32'h0000_0010);   // next block, line 1
        send_request(32'hFFFF_FFFF);   // top address, line 15
        send_request(32'hFFFF_FFF0);   // hit on line 15
        send_request(32'h0000_0100);   // conflict evicts line 0
        send_request(32'h0000_0000);   // evicted block misses again

        // small address limit: boundary and above
        configure(ctlf_pkg::MODE_DIRECT, 5'd4, 3'd4, 32'h0000_FFFF);
        send_request(32'h0000_FFFF);
        send_request(32'h0001_0000);
        send_request(32'hFFFF_FFFF);

        // associative over four lines, entries left from direct mode still hit
        configure(ctlf_pkg::MODE_ASSOC, 5'd4, 3'd2, 32'hFFFF_FFFF);
        send_request(32'h0000_0000);
        send_request(32'h0000_0020);   // fills the empty line 2
        send_request(32'h0000_0030);   // fills line 3
        send_request(32'h0000_0040);   // all full, replaces at pointer 0
        send_request(32'h0000_0050);   // replaces at pointer 1

        // shrink to two lines: pointer now stale, wraps to zero
        configure(ctlf_pkg::MODE_ASSOC, 5'd4, 3'd1, 32'hFFFF_FFFF);
        send_request(32'h0000_0060);

        // widest block offset, line count saturates
        configure(ctlf_pkg::MODE_ASSOC, 5'd31, 3'd7, 32'hFFFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'h7FFF_FFFF);

        // byte sized blocks in a single line
        configure(ctlf_pkg::MODE_DIRECT, 5'd0, 3'd0, 32'hFFFF_FFFF);
        send_request(32'h1234_5678);
        send_request(32'h1234_5678);
        send_request(32'h1234_5679);
        send_request(32'hFFFF_FFFF);

        // lowest limit: only address zero is in range
        configure(ctlf_pkg::MODE_DIRECT, 5'd0, 3'd0, 32'h0000_0000);
        send_request(32'h0000_0000);
        send_request(32'h0000_0001);

        // random phases, each with its own config and idling pattern
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            cur_mode = t_idle_mode'(p % 4);
            if (p == 0) begin
                mode_v  = ctlf_pkg::MODE_DIRECT;
                offs_v  = 5'd0;
                lb_v    = 3'd7;
                limit_v = 32'hFFFF_FFFF;
            end else if (p == 1) begin
                mode_v  = ctlf_pkg::MODE_ASSOC;
                offs_v  = 5'd31;
                lb_v    = 3'd0;
                limit_v = 32'h7FFF_FFFF;
            end else begin
                mode_v  = 1'($urandom_range(1));
                offs_v  = ($urandom_range(99) < 75) ? 5'($urandom_range(8, 2))
                                                    : 5'($urandom_range(31));
                lb_v    = 3'($urandom_range(7));
                limit_v = ($urandom_range(99) < 60) ? 32'hFFFF_FFFF : $urandom;
            end
            configure(mode_v, offs_v, lb_v, limit_v);

            send_idle_pct  = (cur_mode == IDLE_SEND) ? 54 : (cur_mode == IDLE_BOTH) ? 6 : 0;
            recv_stall_pct = (cur_mode == IDLE_RECV) ? 54 : (cur_mode == IDLE_BOTH) ? 6 : 0;

            // working set sized around the line count so hits and evictions both happen
            pool_size = $urandom_range(POOL_MAX, 2);
            for (int k = 0; k < pool_size; k++)
                pool[k] = ($urandom_range(99) < 85) ? $urandom_range(limit_v, 0) : $urandom;
            low_mask = (32'h1 << offs_v) - 32'h1;

            // receiver goes dark while the sender keeps pushing
            if (p == 2) hold_asks++;

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // sender pause until the block has answered everything
                if (p == 3 && n == PHASE_REQUESTS / 2) drain_requests();
                sel = $urandom_range(99);
                if (sel < 70) begin
                    addr = pool[$urandom_range(pool_size - 1)] ^ ($urandom & low_mask);
                end else if (sel < 90) begin
                    addr = $urandom;
                end else begin
                    case ($urandom_range(3))
                        0:       addr = 32'h0000_0000;
                        1:       addr = 32'hFFFF_FFFF;
                        2:       addr = limit_v;
                        default: addr = limit_v + 32'h1;
                    endcase
                end
                send_request(addr);
            end
        end

        drain_requests();
        if (sb.mismatches == 0 && sb.answers_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
